// ----- sv/sess_pkg.sv -----
// ----------------------------------------------------------------------------
// Snapshot scheduler package
// Shared types and constants for the snapshot scheduler and its divider.
// ----------------------------------------------------------------------------
package sess_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TIME_BUDG = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ITER_BUDG = CFG_IDX_W'(3);

  // Request codes
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // One second in 10-bit fixed point
  localparam logic [32:0] ONE_SECOND = 33'd1024;

  // Divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int unsigned DIV_STEPS_W = 6;
  localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_TIME = DIV_STEPS_W'(32);
  localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_ITER = DIV_STEPS_W'(16);

  typedef struct packed {
    logic                   start;
    logic [DIV_STEPS_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_sts_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRE,
    ST_TIME,
    ST_TDIV,
    ST_ITER,
    ST_IDIV,
    ST_FINISH
  } state_t;

endpackage

// ----- sv/sess_div.sv -----
// ----------------------------------------------------------------------------
// Snapshot scheduler divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// time and iteration rescheduling steps.
// ----------------------------------------------------------------------------
module sess_div (
  input  logic                clk,
  input  logic                rst_n,
  input  sess_pkg::div_req_t  req,
  input  logic [31:0]         dividend,
  input  logic [15:0]         divisor,
  output sess_pkg::div_sts_t  sts
);

  logic [sess_pkg::DIV_STEPS_W-1:0] cnt_r, cnt_nxt;
  logic                             done_r, done_nxt;
  logic [31:0]                      quo_r, quo_nxt;
  logic [15:0]                      rem_r, rem_nxt;
  logic [15:0]                      dvs_r, dvs_nxt;
  logic [16:0]                      shifted;
  logic [17:0]                      diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted  = {rem_r, quo_r[31]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      cnt_nxt = req.steps;
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (diff[17]) begin
        rem_nxt = shifted[15:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end else begin
        rem_nxt = diff[15:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end
      done_nxt = (cnt_r == sess_pkg::DIV_STEPS_W'(1));
    end
  end

  // Control state is reset, the data path is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

// ----- sv/snapshot_even_spread_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Snapshot even-spread scheduler
// Decides when a loop bounded by time and iteration count takes snapshots.
// ----------------------------------------------------------------------------
// One transaction at a time. A report that does not fire goes from the
// idle state through the fire state to the finish state, which loads the
// output register. A start or a firing report also passes through the
// time and iteration states, and spreading the remaining time or the
// remaining iterations by division adds a run of the divider in its own
// state. The single shared restoring divider retires one quotient bit per
// cycle and serves both steps in turn, so each transaction waits for its
// divider runs to finish before the next one is accepted. A
// result that is not taken holds the sequencer in its last step until the
// output register frees up. The next input transaction is accepted as
// soon as the sequencer is idle, even while the previous result still
// waits in the output register. Configuration writes are always ready.
module snapshot_even_spread_scheduler_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sess_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [31:0]                     in_now_time,
  input  logic [15:0]                     in_now_iteration,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_take_snapshot,
  output logic [32:0]                     out_next_fire_time,
  output logic [16:0]                     out_next_fire_iteration,
  output logic [15:0]                     out_fired_count
);

  // Configuration registers
  logic [15:0] target_r, interval_r, iter_budget_r;
  logic [31:0] time_budget_r;

  // Scheduler state
  logic [15:0] fire_count_r, fire_count_nxt;
  logic [32:0] time_mark_r, time_mark_nxt;
  logic [16:0] iter_mark_r, iter_mark_nxt;

  // Sequencer and working registers
  sess_pkg::state_t   state_r, state_nxt;
  logic               req_r;
  logic [31:0]        t_r;
  logic [15:0]        i_r;
  logic               fire_r;
  logic signed [16:0] owed_r;
  logic signed [16:0] left;
  logic               owed_pos;
  logic               sched;
  logic               hit;
  logic               time_div;
  logic               iter_div;
  logic               out_load;

  // Output register
  logic        out_valid_r;
  logic        out_take_r;
  logic [32:0] out_time_r;
  logic [16:0] out_iter_r;
  logic [15:0] out_count_r;

  // Divider interface
  sess_pkg::div_req_t div_req;
  sess_pkg::div_sts_t div_sts;
  logic [31:0]        div_dividend;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= '0;
      interval_r    <= '0;
      time_budget_r <= '0;
      iter_budget_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sess_pkg::REG_TARGET:    target_r      <= cfg_data[15:0];
        sess_pkg::REG_INTERVAL:  interval_r    <= cfg_data[15:0];
        sess_pkg::REG_TIME_BUDG: time_budget_r <= cfg_data;
        sess_pkg::REG_ITER_BUDG: iter_budget_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Decision terms used by both the sequencer and the data path.
  always_comb begin
    hit      = ({1'b0, t_r} >= time_mark_r) || ({1'b0, i_r} >= iter_mark_r);
    sched    = (req_r == sess_pkg::REQ_START) ||
               (((target_r != '0) || (interval_r != '0)) && hit);
    owed_pos = !owed_r[16] && (owed_r != '0);
    left     = $signed({1'b0, iter_budget_r}) - $signed({1'b0, i_r});
    time_div = owed_pos && (time_budget_r > t_r);
    iter_div = (target_r != '0) && owed_pos && (left != '0) && !(owed_r >= left);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sess_pkg::ST_IDLE:   if (in_valid) state_nxt = sess_pkg::ST_FIRE;
      sess_pkg::ST_FIRE:   state_nxt = sched ? sess_pkg::ST_TIME : sess_pkg::ST_FINISH;
      sess_pkg::ST_TIME:   state_nxt = time_div ? sess_pkg::ST_TDIV : sess_pkg::ST_ITER;
      sess_pkg::ST_TDIV:   if (div_sts.done) state_nxt = sess_pkg::ST_ITER;
      sess_pkg::ST_ITER:   state_nxt = iter_div ? sess_pkg::ST_IDIV : sess_pkg::ST_FINISH;
      sess_pkg::ST_IDIV:   if (div_sts.done) state_nxt = sess_pkg::ST_FINISH;
      sess_pkg::ST_FINISH: if (out_load) state_nxt = sess_pkg::ST_IDLE;
      default:             state_nxt = sess_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.steps = sess_pkg::DIV_STEPS_TIME;
    div_dividend  = time_budget_r - t_r;
    unique case (state_r)
      sess_pkg::ST_IDLE:   in_ready = 1'b1;
      sess_pkg::ST_TIME:   div_req.start = time_div;
      sess_pkg::ST_ITER: begin
        div_req.start = iter_div;
        div_req.steps = sess_pkg::DIV_STEPS_ITER;
        div_dividend  = {left[15:0], 16'h0000};
      end
      sess_pkg::ST_FINISH: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Mark and count updates
  always_comb begin
    time_mark_nxt  = time_mark_r;
    iter_mark_nxt  = iter_mark_r;
    fire_count_nxt = fire_count_r;
    unique case (state_r)
      sess_pkg::ST_TIME: begin
        if (!owed_pos) begin
          time_mark_nxt = {1'b0, time_budget_r} + sess_pkg::ONE_SECOND;
        end else if (!time_div) begin
          time_mark_nxt = {1'b0, t_r};
        end
      end
      sess_pkg::ST_TDIV: begin
        if (div_sts.done) begin
          time_mark_nxt = {1'b0, t_r} + {1'b0, div_sts.quotient};
        end
      end
      sess_pkg::ST_ITER: begin
        if (target_r == '0) begin
          iter_mark_nxt = {1'b0, i_r} + {1'b0, interval_r};
        end else if (!owed_pos) begin
          iter_mark_nxt = {1'b0, iter_budget_r} + 17'd1;
        end else if (!iter_div) begin
          iter_mark_nxt = {1'b0, i_r} + 17'd1;
        end
      end
      sess_pkg::ST_IDIV: begin
        if (div_sts.done) begin
          iter_mark_nxt = {1'b0, i_r} + {1'b0, div_sts.quotient[15:0]};
        end
      end
      sess_pkg::ST_FINISH: begin
        if (fire_r && (fire_count_r != 16'hFFFF)) begin
          fire_count_nxt = fire_count_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sess_pkg::ST_IDLE;
      fire_count_r <= '0;
      time_mark_r  <= '0;
      iter_mark_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (!(state_r == sess_pkg::ST_FINISH) || out_load) begin
        fire_count_r <= fire_count_nxt;
      end
      time_mark_r <= time_mark_nxt;
      iter_mark_r <= iter_mark_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers: capture the transaction, then decide.
  always_ff @(posedge clk) begin
    if (state_r == sess_pkg::ST_IDLE && in_valid) begin
      req_r <= in_req_type;
      t_r   <= in_now_time;
      i_r   <= in_now_iteration;
    end
    if (state_r == sess_pkg::ST_FIRE) begin
      owed_r <= $signed({1'b0, target_r}) - $signed({1'b0, fire_count_r});
      fire_r <= (req_r == sess_pkg::REQ_REPORT) && sched;
      if (req_r == sess_pkg::REQ_START) begin
        t_r <= '0;
        i_r <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_take_r  <= fire_r;
      out_time_r  <= time_mark_r;
      out_iter_r  <= iter_mark_r;
      out_count_r <= fire_count_nxt;
    end
  end

  sess_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (owed_r[15:0]),
    .sts      (div_sts)
  );

  assign out_valid               = out_valid_r;
  assign out_take_snapshot       = out_take_r;
  assign out_next_fire_time      = out_time_r;
  assign out_next_fire_iteration = out_iter_r;
  assign out_fired_count         = out_count_r;

endmodule

// ----- sv/sess_chk.sv -----
// ----------------------------------------------------------------------------
// Snapshot scheduler port checker
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
module sess_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_take_snapshot,
  input logic [32:0] out_next_fire_time,
  input logic [16:0] out_next_fire_iteration,
  input logic [15:0] out_fired_count
);

  // Type of the most recently accepted input transaction.
  logic last_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_req_r <= sess_pkg::REQ_START;
    end else if (in_valid && in_ready) begin
      last_req_r <= in_req_type;
    end
  end

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_take_snapshot) &&
      $stable(out_next_fire_time) && $stable(out_next_fire_iteration) &&
      $stable(out_fired_count))
    else $error("result changed while stalled");

  // No result is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A snapshot taken is always counted.
  a_fire_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_take_snapshot |-> out_fired_count != 16'd0)
    else $error("snapshot fired with zero count");

  // A start transaction never fires.
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && last_req_r == sess_pkg::REQ_START |-> !out_take_snapshot)
    else $error("start transaction fired a snapshot");

endmodule

bind snapshot_even_spread_scheduler_unit sess_chk u_sess_chk (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_ready                (in_ready),
  .in_req_type             (in_req_type),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_take_snapshot       (out_take_snapshot),
  .out_next_fire_time      (out_next_fire_time),
  .out_next_fire_iteration (out_next_fire_iteration),
  .out_fired_count         (out_fired_count)
);

// ----- tb/snapshot_even_spread_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapshot even-spread scheduler testbench
// A queue-fed driver sends start and report transactions while a monitor
// checks each result against a scheduler model kept inside the bench. Loops
// are well-formed runs of progress reports under changing register settings,
// mixed with noise, followed by a short run with a full target.
// ----------------------------------------------------------------------------
module snapshot_even_spread_scheduler_unit_tb;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic        req;
    logic [31:0] now_t;
    logic [15:0] now_i;
  } loop_req_t;

  typedef struct {
    logic        fire;
    logic [32:0] time_mark;
    logic [16:0] iter_mark;
    logic [15:0] fires;
  } sched_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sess_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_req_type = 1'b0;
  logic [31:0]                    in_now_time = '0;
  logic [15:0]                    in_now_iteration = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_take_snapshot;
  logic [32:0]                    out_next_fire_time;
  logic [16:0]                    out_next_fire_iteration;
  logic [15:0]                    out_fired_count;

  // Register copies and scheduler state of the model.
  logic [15:0] cfg_target = '0;
  logic [15:0] cfg_interval = '0;
  logic [31:0] cfg_time_budget = '0;
  logic [15:0] cfg_iter_budget = '0;
  logic [15:0] sched_fires = '0;
  logic [32:0] sched_time_mark = '0;
  logic [16:0] sched_iter_mark = '0;

  loop_req_t     loop_reqs_q[$];
  sched_result_t sched_expect_q[$];
  int            err_cnt = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            stall_cycles = 0;

  snapshot_even_spread_scheduler_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_req_type             (in_req_type),
    .in_now_time             (in_now_time),
    .in_now_iteration        (in_now_iteration),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_take_snapshot       (out_take_snapshot),
    .out_next_fire_time      (out_next_fire_time),
    .out_next_fire_iteration (out_next_fire_iteration),
    .out_fired_count         (out_fired_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Snapshots still owed, as a signed count.
  function automatic int owed_count();
    return int'({16'd0, cfg_target} - {16'd0, sched_fires});
  endfunction

  // Next time mark when rescheduling from time t.
  function automatic logic [32:0] spread_time_mark(input logic [31:0] t);
    int          owed;
    logic [31:0] share;
    owed = owed_count();
    if (owed <= 0) return {1'b0, cfg_time_budget} + sess_pkg::ONE_SECOND;
    if (cfg_time_budget <= t) return {1'b0, t};
    share = (cfg_time_budget - t) / 32'(owed);
    return {1'b0, t} + {1'b0, share};
  endfunction

  // Next iteration mark when rescheduling from iteration i.
  function automatic logic [16:0] spread_iter_mark(input logic [15:0] i);
    int owed;
    int left;
    if (cfg_target != 16'd0) begin
      owed = owed_count();
      if (owed <= 0) return {1'b0, cfg_iter_budget} + 17'd1;
      left = int'({16'd0, cfg_iter_budget} - {16'd0, i});
      if (left == 0 || owed >= left) return {1'b0, i} + 17'd1;
      return {1'b0, i} + 17'(left / owed);
    end
    return {1'b0, i} + {1'b0, cfg_interval};
  endfunction

  // Apply one accepted transaction to the model and give its result.
  task automatic advance_schedule(input logic req, input logic [31:0] t,
                                  input logic [15:0] i, output sched_result_t res);
    res.fire = 1'b0;
    if (req == sess_pkg::REQ_START) begin
      sched_time_mark = spread_time_mark(32'd0);
      sched_iter_mark = spread_iter_mark(16'd0);
    end else if (cfg_target != 16'd0 || cfg_interval != 16'd0) begin
      if ({1'b0, t} >= sched_time_mark || {1'b0, i} >= sched_iter_mark) begin
        res.fire = 1'b1;
        sched_time_mark = spread_time_mark(t);
        sched_iter_mark = spread_iter_mark(i);
        if (sched_fires != 16'hFFFF) sched_fires = sched_fires + 16'd1;
      end
    end
    res.time_mark = sched_time_mark;
    res.iter_mark = sched_iter_mark;
    res.fires     = sched_fires;
  endtask

  task automatic flag_mismatch(input string what, input logic [32:0] got,
                               input logic [32:0] want);
    $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic push_req(input logic req, input logic [31:0] t, input logic [15:0] i);
    loop_req_t r;
    r.req   = req;
    r.now_t = t;
    r.now_i = i;
    loop_reqs_q.insert(loop_reqs_q.size(), r);
  endtask

  // Block until every queued transaction has been sent and answered. The
  // check runs at the falling edge, once the driver's updates have settled,
  // and the task returns at the following rising edge.
  task automatic wait_idle();
    @(negedge clk);
    while (loop_reqs_q.size() != 0 || in_valid || sched_expect_q.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // One register write; called at a rising edge, returns at the accepting edge.
  task automatic cfg_write(input logic [sess_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sess_pkg::REG_TARGET:    cfg_target      = data[15:0];
      sess_pkg::REG_INTERVAL:  cfg_interval    = data[15:0];
      sess_pkg::REG_TIME_BUDG: cfg_time_budget = data;
      sess_pkg::REG_ITER_BUDG: cfg_iter_budget = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int tgt, input int ivl, input logic [31:0] tb,
                            input int ib);
    cfg_write(sess_pkg::REG_TARGET, 32'(tgt));
    cfg_write(sess_pkg::REG_INTERVAL, 32'(ivl));
    cfg_write(sess_pkg::REG_TIME_BUDG, tb);
    cfg_write(sess_pkg::REG_ITER_BUDG, 32'(ib));
    // Writes to indexes past the register list must be dropped.
    if ($urandom_range(3, 0) == 0)
      cfg_write(sess_pkg::CFG_IDX_W'($urandom_range(255,
                int'(sess_pkg::REG_ITER_BUDG) + 1)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Pick a register setting, leaning toward a few snapshots still owed.
  task automatic random_config();
    int          tgt;
    int          ivl;
    logic [31:0] tb;
    int          ib;
    case ($urandom_range(7, 0))
      0, 1:    tgt = 0;
      2:       tgt = 65535;
      3:       tgt = int'(sched_fires);
      default: tgt = int'(sched_fires) + int'($urandom_range(40, 1));
    endcase
    if (tgt > 65535) tgt = 65535;
    case ($urandom_range(5, 0))
      0:       ivl = 0;
      1:       ivl = 65535;
      2:       ivl = 1;
      3:       ivl = $urandom_range(65535, 0);
      default: ivl = $urandom_range(50, 1);
    endcase
    case ($urandom_range(5, 0))
      0:       tb = 32'd0;
      1:       tb = 32'hFFFF_FFFF;
      2, 3:    tb = $urandom;
      default: tb = $urandom_range(200000, 0);
    endcase
    case ($urandom_range(5, 0))
      0:       ib = 0;
      1:       ib = 65535;
      2:       ib = $urandom_range(65535, 0);
      default: ib = $urandom_range(500, 0);
    endcase
    set_config(tgt, ivl, tb, ib);
  endtask

  // One loop: a start, then n progress reports moving forward, with noise.
  task automatic gen_loop(input int n);
    longint unsigned t;
    longint unsigned i;
    longint unsigned tstep;
    longint unsigned istep;
    t = 0;
    i = 0;
    tstep = longint'(cfg_time_budget) * 2 / n + 3;
    if (tstep > 64'hFFFF_FFFF) tstep = 64'hFFFF_FFFF;
    istep = longint'(cfg_iter_budget) * 2 / n + cfg_interval / 2 + 2;
    push_req(sess_pkg::REQ_START, $urandom, 16'($urandom));
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(19, 0))
        0: push_req(sess_pkg::REQ_REPORT, $urandom, 16'($urandom));
        1: push_req(sess_pkg::REQ_START, $urandom, 16'($urandom));
        default: begin
          if ($urandom_range(9, 0) == 0) begin
            t = t + tstep * 8;
            i = i + istep * 8;
          end else begin
            t = t + $urandom_range(32'(tstep), 0);
            i = i + $urandom_range(32'(istep), 0);
          end
          if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
          if (i > 64'hFFFF) i = 64'hFFFF;
          push_req(sess_pkg::REQ_REPORT, 32'(t), 16'(i));
        end
      endcase
    end
  endtask

  // Driver: predict each accepted transaction, then present the next one.
  always @(posedge clk) begin : drive_reqs
    loop_req_t     r;
    sched_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_schedule(in_req_type, in_now_time, in_now_iteration, res);
        sched_expect_q.insert(sched_expect_q.size(), res);
      end
      if (!in_valid || in_ready) begin
        if (loop_reqs_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          r = loop_reqs_q.pop_front();
          in_valid         <= 1'b1;
          in_req_type      <= r.req;
          in_now_time      <= r.now_t;
          in_now_iteration <= r.now_i;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and field-by-field result checks.
  always @(posedge clk) begin : check_results
    sched_result_t want;
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (sched_expect_q.size() == 0) begin
        flag_mismatch("unexpected result, fired_count", 33'(out_fired_count), 33'd0);
      end else begin
        want = sched_expect_q.pop_front();
        if (out_take_snapshot !== want.fire)
          flag_mismatch("take_snapshot", 33'(out_take_snapshot), 33'(want.fire));
        if (out_next_fire_time !== want.time_mark)
          flag_mismatch("next_fire_time", out_next_fire_time, want.time_mark);
        if (out_next_fire_iteration !== want.iter_mark)
          flag_mismatch("next_fire_iteration", 33'(out_next_fire_iteration),
                        33'(want.iter_mark));
        if (out_fired_count !== want.fires)
          flag_mismatch("fired_count", 33'(out_fired_count), 33'(want.fires));
      end
    end
  end

  // Watchdog: end the run when no channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL snapshot_even_spread_scheduler_unit");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : main_seq
    int made;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct <= 36;
    recv_idle_pct <= 49;

    // Both modes off: reports never fire and leave the reset marks alone.
    set_config(0, 0, 32'd0, 0);
    push_req(sess_pkg::REQ_REPORT, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(sess_pkg::REQ_REPORT, 32'd5, 16'd3);
    wait_idle();

    // Interval mode; the first report comes before any start and fires.
    set_config(0, 7, 32'd5000, 100);
    push_req(sess_pkg::REQ_REPORT, 32'd0, 16'd0);
    push_req(sess_pkg::REQ_REPORT, 32'd3, 16'd5);
    push_req(sess_pkg::REQ_REPORT, 32'd3, 16'd9);
    push_req(sess_pkg::REQ_START, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(sess_pkg::REQ_REPORT, 32'd0, 16'd6);
    push_req(sess_pkg::REQ_REPORT, 32'd0, 16'd7);
    wait_idle();

    // Target mode with interval also set; time then iteration budget run out.
    set_config(int'(sched_fires) + 4, 65535, 32'd10240, 100);
    push_req(sess_pkg::REQ_START, 32'd0, 16'd0);
    push_req(sess_pkg::REQ_REPORT, 32'd1000, 16'd10);
    push_req(sess_pkg::REQ_REPORT, 32'd2600, 16'd25);
    push_req(sess_pkg::REQ_REPORT, 32'd9000, 16'd40);
    push_req(sess_pkg::REQ_REPORT, 32'd12000, 16'd50);
    push_req(sess_pkg::REQ_REPORT, 32'd12000, 16'd150);
    push_req(sess_pkg::REQ_REPORT, 32'd13000, 16'd160);
    push_req(sess_pkg::REQ_REPORT, 32'd13000, 16'd161);
    wait_idle();

    // Every register at its top value.
    set_config(65535, 65535, 32'hFFFF_FFFF, 65535);
    push_req(sess_pkg::REQ_START, 32'd0, 16'd0);
    push_req(sess_pkg::REQ_REPORT, 32'hFFFF_FFFF, 16'd0);
    push_req(sess_pkg::REQ_REPORT, 32'd0, 16'hFFFF);
    push_req(sess_pkg::REQ_REPORT, 32'd0, 16'd0);
    wait_idle();

    // Zero budgets with one snapshot owed.
    set_config(int'(sched_fires) + 1, 0, 32'd0, 0);
    push_req(sess_pkg::REQ_START, 32'd0, 16'd0);
    push_req(sess_pkg::REQ_REPORT, 32'd0, 16'd0);
    push_req(sess_pkg::REQ_REPORT, 32'd0, 16'd0);
    wait_idle();

    // Random loops under three back-pressure profiles.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct <= 36;
          recv_idle_pct <= 49;
        end
        1: begin
          send_idle_pct <= 49;
          recv_idle_pct <= 36;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      made = 0;
      while (made < 620) begin
        wait_idle();
        random_config();
        n = $urandom_range(40, 8);
        gen_loop(n);
        made += n + 1;
      end
    end

    // A full target with the interval also set.
    wait_idle();
    set_config(65535, 3, $urandom, $urandom_range(65535, 0));
    gen_loop(12);
    wait_idle();

    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS snapshot_even_spread_scheduler_unit");
    end else begin
      $display("FAIL snapshot_even_spread_scheduler_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/sess_pkg.sv
sv/sess_div.sv
sv/snapshot_even_spread_scheduler_unit.sv
sv/sess_chk.sv
tb/snapshot_even_spread_scheduler_unit_tb.sv
